@@ src/tsb_pkg.sv @@
// shared types, constants and helpers of the terminal screen buffer
`default_nettype none
package tsb_pkg;

  localparam int MAX_COLS_DEF = 128;
  localparam int MAX_ROWS_DEF = 64;

  localparam int NUM_W     = 12;
  localparam int CELL_W    = 38;
  localparam int IN_DATA_W = 80;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [7:0]  RST_COLS = 8'd80;
  localparam logic [6:0]  RST_ROWS = 7'd25;
  localparam logic [15:0] RST_ATTR = 16'd7;
  localparam logic [20:0] BLANK_CHAR = 21'h20;

  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTR = 2'd2;

  localparam logic [4:0] OP_PUT     = 5'd0;
  localparam logic [4:0] OP_SETCUR  = 5'd1;
  localparam logic [4:0] OP_MOVECUR = 5'd2;
  localparam logic [4:0] OP_SAVE    = 5'd3;
  localparam logic [4:0] OP_RESTORE = 5'd4;
  localparam logic [4:0] OP_ED      = 5'd5;
  localparam logic [4:0] OP_EL      = 5'd6;
  localparam logic [4:0] OP_REGION  = 5'd7;
  localparam logic [4:0] OP_SCROLL  = 5'd8;
  localparam logic [4:0] OP_INSL    = 5'd9;
  localparam logic [4:0] OP_DELL    = 5'd10;
  localparam logic [4:0] OP_INSC    = 5'd11;
  localparam logic [4:0] OP_DELC    = 5'd12;
  localparam logic [4:0] OP_CLEAN   = 5'd13;
  localparam logic [4:0] OP_DIRTY   = 5'd14;
  localparam logic [4:0] OP_SETATTR = 5'd15;
  localparam logic [4:0] OP_READ    = 5'd16;

  typedef logic signed [NUM_W-1:0] num_t;

  typedef struct packed {
    logic        cp_en;
    logic        rdir;
    logic        cdir;
    logic        blk_en;
    logic        dirty_en;
    num_t        rs;
    num_t        re;
    num_t        roff;
    num_t        cs;
    num_t        ce;
    num_t        coff;
    num_t        bs;
    num_t        be;
    num_t        xs;
    num_t        xe;
    num_t        d_lo;
    num_t        d_hi;
  } plan_t;

  typedef struct packed {
    logic [5:0]  scroll_bottom_row;
    logic [5:0]  scroll_top_row;
    logic        repaint_req;
    logic        wrap_pending;
    logic [5:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic        row_dirty;
    logic        cell_valid;
    logic        cell_wide_trail;
    logic [15:0] cell_attributes;
    logic [20:0] cell_codepoint;
  } res_t;

  function automatic num_t clampn(num_t v, num_t hi);
    if (v < 0) return '0;
    if (v > hi) return hi;
    return v;
  endfunction

endpackage
`default_nettype wire

@@ src/tsb_ram.sv @@
// generic single write, single read ram with registered read data
`default_nettype none
module tsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ src/tsb_engine.sv @@
// command sequencer: cursor state, dirty marks and cell walks over the cell ram
`default_nettype none
module tsb_engine import tsb_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  localparam int AW = $clog2(MAX_COLS * MAX_ROWS)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata,
  output logic                      rsp_valid,
  input  wire logic                 rsp_ready,
  output res_t                      rsp,
  output logic                      ram_we,
  output logic [AW-1:0]             ram_waddr,
  output logic [CELL_W-1:0]         ram_wdata,
  output logic                      ram_re,
  output logic [AW-1:0]             ram_raddr,
  input  wire logic [CELL_W-1:0]    ram_rdata
);
  localparam int CIW = $clog2(MAX_COLS);
  localparam int RIW = $clog2(MAX_ROWS);
  localparam int DEPTH = MAX_COLS * MAX_ROWS;

  typedef enum logic [7:0] {
    S_CLR  = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_PLAN = 8'b0000_0100,
    S_CRD  = 8'b0000_1000,
    S_CWR  = 8'b0001_0000,
    S_BLK  = 8'b0010_0000,
    S_FIN  = 8'b0100_0000,
    S_RSP  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]  cols_r;
  logic [6:0]  rows_r;
  logic [15:0] dattr_r;
  logic [CIW-1:0] cur_col_r, saved_col_r;
  logic [RIW-1:0] cur_row_r, saved_row_r, rtop_r, rbot_r;
  logic wrap_r, repaint_r;
  logic [15:0] cur_attr_r, saved_attr_r;
  logic [MAX_ROWS-1:0] dirty_r;
  logic [AW-1:0] clr_r;

  logic [4:0]        op_r;
  logic signed [8:0] ca_r, ra_r, ba_r, cnt_r;
  logic [20:0]       cp_r;
  logic [15:0]       av_r;
  logic              cvalid_r;

  plan_t plan_r, plan_c;
  num_t wy_r, wx_r;
  num_t w_now, h_now, ccol, crow, cnt, ra, row_end, cnt_c;
  logic put_scroll;

  function automatic num_t w_of(logic [7:0] c);
    if (c == '0) return num_t'(1);
    if (num_t'(c) > num_t'(MAX_COLS)) return num_t'(MAX_COLS);
    return num_t'(c);
  endfunction

  function automatic num_t h_of(logic [6:0] r);
    if (r == '0) return num_t'(1);
    if (num_t'(r) > num_t'(MAX_ROWS)) return num_t'(MAX_ROWS);
    return num_t'(r);
  endfunction

  function automatic logic [AW-1:0] addr_of(num_t r, num_t c);
    return AW'(AW'(r[RIW-1:0]) * AW'(MAX_COLS)) + AW'(c[CIW-1:0]);
  endfunction

  function automatic plan_t scroll_plan(num_t top, num_t bot, num_t lines, num_t w);
    plan_t p;
    num_t rh;
    num_t l;
    p = '0;
    rh = bot - top + num_t'(1);
    l = lines;
    if (l != '0) begin
      if (l > rh) l = rh;
      if (l < -rh) l = -rh;
      p.dirty_en = 1'b1;
      p.d_lo = top;
      p.d_hi = bot;
      p.cs = '0;
      p.ce = num_t'(MAX_COLS - 1);
      p.blk_en = 1'b1;
      p.xs = '0;
      p.xe = w - num_t'(1);
      p.roff = l;
      if (l > 0) begin
        p.rs = top;
        p.re = bot - l;
        p.cp_en = (top <= bot - l);
        p.bs = bot - l + num_t'(1);
        p.be = bot;
      end else begin
        p.rdir = 1'b1;
        p.rs = bot;
        p.re = top - l;
        p.cp_en = (bot >= top - l);
        p.bs = top;
        p.be = top - l - num_t'(1);
      end
    end
    return p;
  endfunction

  assign w_now = w_of(cols_r);
  assign h_now = h_of(rows_r);
  assign ccol  = num_t'(cur_col_r);
  assign crow  = num_t'(cur_row_r);
  assign cnt   = num_t'(cnt_r);
  assign ra    = num_t'(ra_r);
  assign put_scroll = (op_r == OP_PUT) && wrap_r && (crow + num_t'(1) > num_t'(rbot_r));
  assign cnt_c = (cnt > w_now - ccol) ? (w_now - ccol) : cnt;
  assign row_end = (wy_r == plan_r.be) ? plan_r.xe : (w_now - num_t'(1));

  always_comb begin
    plan_c = '0;
    unique case (op_r)
      OP_PUT:
        if (put_scroll) plan_c = scroll_plan(num_t'(rtop_r), num_t'(rbot_r), num_t'(1), w_now);
      OP_SCROLL: plan_c = scroll_plan(num_t'(rtop_r), num_t'(rbot_r), cnt, w_now);
      OP_INSL, OP_DELL:
        if (cnt > 0 && cur_row_r >= rtop_r && cur_row_r <= rbot_r)
          plan_c = scroll_plan(crow, num_t'(rbot_r), (op_r == OP_INSL) ? -cnt : cnt, w_now);
      OP_ED: begin
        plan_c.xe = w_now - num_t'(1);
        plan_c.be = h_now - num_t'(1);
        plan_c.d_hi = h_now - num_t'(1);
        if (cnt == 0) begin
          plan_c.blk_en = 1'b1;
          plan_c.dirty_en = 1'b1;
          plan_c.bs = crow;
          plan_c.xs = ccol;
          plan_c.d_lo = crow;
        end else if (cnt == 1) begin
          plan_c.blk_en = 1'b1;
          plan_c.dirty_en = 1'b1;
          plan_c.be = crow;
          plan_c.xe = ccol;
          plan_c.d_hi = crow;
        end else if (cnt == 2 || cnt == 3) begin
          plan_c.blk_en = 1'b1;
          plan_c.dirty_en = 1'b1;
        end
      end
      OP_EL: begin
        plan_c.dirty_en = 1'b1;
        plan_c.d_lo = crow;
        plan_c.d_hi = crow;
        plan_c.bs = crow;
        plan_c.be = crow;
        plan_c.xe = w_now - num_t'(1);
        plan_c.blk_en = (cnt == 0) || (cnt == 1) || (cnt == 2);
        if (cnt == 0) plan_c.xs = ccol;
        if (cnt == 1) plan_c.xe = ccol;
      end
      OP_INSC, OP_DELC:
        if (cnt > 0) begin
          plan_c.dirty_en = 1'b1;
          plan_c.d_lo = crow;
          plan_c.d_hi = crow;
          plan_c.rs = crow;
          plan_c.re = crow;
          plan_c.blk_en = 1'b1;
          plan_c.bs = crow;
          plan_c.be = crow;
          plan_c.cp_en = (w_now - ccol - cnt_c) > 0;
          if (op_r == OP_INSC) begin
            plan_c.cdir = 1'b1;
            plan_c.cs = w_now - num_t'(1);
            plan_c.ce = ccol + cnt_c;
            plan_c.coff = -cnt_c;
            plan_c.xs = ccol;
            plan_c.xe = ccol + cnt_c - num_t'(1);
          end else begin
            plan_c.cs = ccol;
            plan_c.ce = w_now - cnt_c - num_t'(1);
            plan_c.coff = cnt_c;
            plan_c.xs = w_now - cnt_c;
            plan_c.xe = w_now - num_t'(1);
          end
        end
      default: plan_c = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:  if (clr_r == AW'(DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE: if (in_tvalid) state_nxt = S_PLAN;
      S_PLAN: begin
        if (plan_c.cp_en) state_nxt = S_CRD;
        else if (plan_c.blk_en) state_nxt = S_BLK;
        else state_nxt = S_FIN;
      end
      S_CRD:  state_nxt = S_CWR;
      S_CWR: begin
        if (wx_r == plan_r.ce && wy_r == plan_r.re)
          state_nxt = plan_r.blk_en ? S_BLK : S_FIN;
        else
          state_nxt = S_CRD;
      end
      S_BLK:  if (wx_r == row_end && wy_r == plan_r.be) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_RSP;
      S_RSP:  if (rsp_ready) state_nxt = S_IDLE;
      default: state_nxt = S_CLR;
    endcase
  end

  always_comb begin
    ram_we = 1'b0;
    ram_re = 1'b0;
    ram_waddr = addr_of(wy_r, wx_r);
    ram_raddr = addr_of(wy_r + plan_r.roff, wx_r + plan_r.coff);
    ram_wdata = {1'b0, dattr_r, BLANK_CHAR};
    unique case (state_r)
      S_CLR: begin
        ram_we = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = {1'b0, RST_ATTR, BLANK_CHAR};
      end
      S_CRD: ram_re = 1'b1;
      S_CWR: begin
        ram_we = 1'b1;
        ram_wdata = ram_rdata;
      end
      S_BLK: ram_we = 1'b1;
      S_FIN: begin
        ram_waddr = addr_of(crow, ccol);
        ram_wdata = {1'b0, cur_attr_r, cp_r};
        ram_we = (op_r == OP_PUT) && (ccol < w_now);
        ram_raddr = addr_of(ra, num_t'(ca_r));
        ram_re = (op_r == OP_READ);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      cols_r <= RST_COLS;
      rows_r <= RST_ROWS;
      dattr_r <= RST_ATTR;
      cur_col_r <= '0;
      cur_row_r <= '0;
      wrap_r <= 1'b0;
      saved_col_r <= '0;
      saved_row_r <= '0;
      saved_attr_r <= '0;
      cur_attr_r <= RST_ATTR;
      rtop_r <= '0;
      rbot_r <= RIW'(h_of(RST_ROWS) - num_t'(1));
      dirty_r <= '0;
      repaint_r <= 1'b1;
      cvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_CLR: clr_r <= clr_r + AW'(1);
        S_IDLE:
          if (in_tvalid) begin
            op_r  <= in_tdata[4:0];
            ca_r  <= in_tdata[13:5];
            ra_r  <= in_tdata[22:14];
            ba_r  <= in_tdata[31:23];
            cnt_r <= in_tdata[40:32];
            cp_r  <= in_tdata[61:41];
            av_r  <= in_tdata[77:62];
          end
        S_PLAN: begin
          plan_r <= plan_c;
          if (plan_c.cp_en) begin
            wy_r <= plan_c.rs;
            wx_r <= plan_c.cs;
          end else begin
            wy_r <= plan_c.bs;
            wx_r <= plan_c.xs;
          end
          if (op_r == OP_PUT && wrap_r) begin
            wrap_r <= 1'b0;
            cur_col_r <= '0;
            cur_row_r <= put_scroll ? rbot_r : RIW'(crow + num_t'(1));
          end
        end
        S_CWR: begin
          if (wx_r == plan_r.ce) begin
            if (wy_r == plan_r.re) begin
              wy_r <= plan_r.bs;
              wx_r <= plan_r.xs;
            end else begin
              wy_r <= plan_r.rdir ? wy_r - num_t'(1) : wy_r + num_t'(1);
              wx_r <= plan_r.cs;
            end
          end else begin
            wx_r <= plan_r.cdir ? wx_r - num_t'(1) : wx_r + num_t'(1);
          end
        end
        S_BLK: begin
          if (wx_r == row_end) begin
            wy_r <= wy_r + num_t'(1);
            wx_r <= '0;
          end else begin
            wx_r <= wx_r + num_t'(1);
          end
        end
        S_FIN: begin
          for (int y = 0; y < MAX_ROWS; y++) begin
            if (plan_r.dirty_en && num_t'(y) >= plan_r.d_lo && num_t'(y) <= plan_r.d_hi)
              dirty_r[y] <= 1'b1;
            if ((op_r == OP_CLEAN || op_r == OP_DIRTY) && num_t'(y) < h_now)
              dirty_r[y] <= (op_r == OP_DIRTY);
            if (op_r == OP_PUT && y == int'(cur_row_r))
              dirty_r[y] <= 1'b1;
          end
          cvalid_r <= (op_r == OP_READ) && (ca_r >= 0) && (num_t'(ca_r) < w_now) &&
                      (ra_r >= 0) && (ra < h_now);
          unique case (op_r)
            OP_PUT: begin
              if (ccol + num_t'(1) >= w_now) begin
                cur_col_r <= CIW'(w_now - num_t'(1));
                wrap_r <= 1'b1;
              end else begin
                cur_col_r <= cur_col_r + CIW'(1);
              end
            end
            OP_SETCUR: begin
              cur_col_r <= CIW'(clampn(num_t'(ca_r), w_now - num_t'(1)));
              cur_row_r <= RIW'(clampn(ra, h_now - num_t'(1)));
              wrap_r <= 1'b0;
            end
            OP_MOVECUR: begin
              cur_col_r <= CIW'(clampn(ccol + num_t'(ca_r), w_now - num_t'(1)));
              cur_row_r <= RIW'(clampn(crow + ra, h_now - num_t'(1)));
              wrap_r <= 1'b0;
            end
            OP_SAVE: begin
              saved_col_r <= cur_col_r;
              saved_row_r <= cur_row_r;
              saved_attr_r <= cur_attr_r;
            end
            OP_RESTORE: begin
              cur_col_r <= CIW'(clampn(num_t'(saved_col_r), w_now - num_t'(1)));
              cur_row_r <= RIW'(clampn(num_t'(saved_row_r), h_now - num_t'(1)));
              wrap_r <= 1'b0;
              cur_attr_r <= saved_attr_r;
            end
            OP_ED: begin
              wrap_r <= 1'b0;
              if (cnt == 2 || cnt == 3) repaint_r <= 1'b1;
            end
            OP_EL: wrap_r <= 1'b0;
            OP_REGION:
              if (clampn(ra, h_now - num_t'(1)) < clampn(num_t'(ba_r), h_now - num_t'(1))) begin
                rtop_r <= RIW'(clampn(ra, h_now - num_t'(1)));
                rbot_r <= RIW'(clampn(num_t'(ba_r), h_now - num_t'(1)));
                cur_col_r <= '0;
                cur_row_r <= '0;
                wrap_r <= 1'b0;
              end
            OP_INSL, OP_DELL:
              if (cnt > 0 && cur_row_r >= rtop_r && cur_row_r <= rbot_r) begin
                cur_col_r <= '0;
                wrap_r <= 1'b0;
              end
            OP_INSC, OP_DELC: if (cnt > 0) wrap_r <= 1'b0;
            OP_CLEAN: repaint_r <= 1'b0;
            OP_DIRTY: repaint_r <= 1'b1;
            OP_SETATTR: cur_attr_r <= av_r;
            default: ;
          endcase
        end
        default: ;
      endcase
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_COLS: begin
            cols_r <= cfg_wdata[7:0];
            cur_col_r <= CIW'(clampn(ccol, w_of(cfg_wdata[7:0]) - num_t'(1)));
            wrap_r <= 1'b0;
          end
          CFG_ROWS: begin
            rows_r <= cfg_wdata[6:0];
            cur_row_r <= RIW'(clampn(crow, h_of(cfg_wdata[6:0]) - num_t'(1)));
            wrap_r <= 1'b0;
            rtop_r <= '0;
            rbot_r <= RIW'(h_of(cfg_wdata[6:0]) - num_t'(1));
          end
          CFG_ATTR: dattr_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign rsp_valid = (state_r == S_RSP);

  always_comb begin
    rsp = '0;
    if (cvalid_r) begin
      rsp.cell_codepoint = ram_rdata[20:0];
      rsp.cell_attributes = ram_rdata[36:21];
      rsp.cell_wide_trail = ram_rdata[37];
    end
    rsp.cell_valid = cvalid_r;
    rsp.row_dirty = (ra_r >= 0) && (ra < h_now) && dirty_r[ra_r[RIW-1:0]];
    rsp.cursor_col = 7'(cur_col_r);
    rsp.cursor_row = 6'(cur_row_r);
    rsp.wrap_pending = wrap_r;
    rsp.repaint_req = repaint_r;
    rsp.scroll_top_row = 6'(rtop_r);
    rsp.scroll_bottom_row = 6'(rbot_r);
  end

  a_col_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> ccol < w_now) else $error("cursor column beyond width");
  a_region_order: assert property (@(posedge clk) disable iff (!rst_n)
    rtop_r <= rbot_r && num_t'(rbot_r) < h_now) else $error("scroll region out of order");
  a_one_port_use: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re)) else $error("read and write in one cycle");

endmodule
`default_nettype wire

@@ src/terminal_screen_buffer_top.sv @@
// terminal screen buffer: command sequencer, cell ram and result register
// a command without a cell walk passes the plan, finish and response states, then the result register
// each copied cell takes a read state and a write state, each blanked cell a write state
// one command in flight at a time
// after reset a clearing pass writes all MAX_COLS*MAX_ROWS cells, one per cycle, no beats taken
// reset restores size 80x25, attribute 7, cursor at home and the repaint flag set
`default_nettype none
module terminal_screen_buffer_top import tsb_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // opcode, col_arg, row_arg, bottom_row, count_arg, codepoint, attr_value
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // cell_codepoint, cell_attributes, cell_wide_trail, cell_valid, row_dirty,
  // cursor_col, cursor_row, wrap_pending, repaint_req, scroll_top_row, scroll_bottom_row
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DAT_W-1:0]  cfg_wdata
);
  localparam int AW = $clog2(MAX_COLS * MAX_ROWS);

  logic              rsp_valid, rsp_ready;
  res_t              rsp, out_r;
  logic              out_valid_r;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  tsb_engine #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_engine (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .cfg_we, .cfg_index, .cfg_wdata,
    .rsp_valid, .rsp_ready, .rsp,
    .ram_we, .ram_waddr, .ram_wdata, .ram_re, .ram_raddr, .ram_rdata
  );

  tsb_ram #(.WIDTH(CELL_W), .DEPTH(MAX_COLS * MAX_ROWS)) u_cells (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign rsp_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp_ready) begin
      out_valid_r <= rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_ready && rsp_valid) out_r <= rsp;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {5'b0, out_r.scroll_bottom_row, out_r.scroll_top_row, out_r.repaint_req,
                      out_r.wrap_pending, out_r.cursor_row, out_r.cursor_col, out_r.row_dirty,
                      out_r.cell_valid, out_r.cell_wide_trail, out_r.cell_attributes,
                      out_r.cell_codepoint};
endmodule
`default_nettype wire
